/* rtl/lsmt_pkg.sv */
// Shared types and timing constants for the LCD scanline mode timer.
package lsmt_pkg;

	localparam int unsigned TicksW  = 8;
	localparam int unsigned LineW   = 8;
	localparam int unsigned EnW     = 4;
	localparam int unsigned FrameW  = 18;
	localparam int unsigned VblW    = 10;
	localparam int unsigned PhaseW  = 9;
	localparam int unsigned SDataW  = 24;
	localparam int unsigned MDataW  = 16;

	localparam logic [FrameW-1:0] VISIBLE_END = 18'd65664;
	localparam logic [FrameW-1:0] FRAME_TOTAL = 18'd70224;
	localparam logic [PhaseW:0]   LINE_CYCLES = 10'd456;
	localparam logic [PhaseW-1:0] OAM_END     = 9'd80;
	localparam logic [PhaseW-1:0] XFER_END    = 9'd252;
	localparam logic [LineW-1:0]  LAST_LINE   = 8'd153;
	localparam logic [VblW-1:0]   VBL_OFFSET  = VISIBLE_END[VblW-1:0];

	localparam int unsigned EN_HBLANK = 0;
	localparam int unsigned EN_VBLANK = 1;
	localparam int unsigned EN_OAM    = 2;
	localparam int unsigned EN_MATCH  = 3;

	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_XFER   = 2'd3
	} mode_t;

	typedef struct packed {
		logic [EnW-1:0]   irq_enables;
		logic [LineW-1:0] line_compare;
		logic [TicksW-1:0] ticks;
	} item_t;

	typedef struct packed {
		logic             render_line;
		logic             vblank_irq;
		logic             stat_irq;
		logic             coincidence;
		logic [LineW-1:0] line;
		mode_t            mode;
	} result_t;

	typedef struct packed {
		logic fire;
		logic advance;
	} flow_t;

endpackage

/* rtl/lcd_scanline_mode_timer_top.sv */
// Top level of the LCD scanline mode timer.
//
//  Channel   Dir  Fields (tdata, low bit up)
//  s_axis    in   ticks[7:0] line_compare[15:8] irq_enables[19:16] pad[23:20]
//  m_axis    out  mode[1:0] line[9:2] coincidence[10] stat_irq[11]
//                 vblank_irq[12] render_line[13] pad[15:14]
//
// One transaction per cycle while the output does not stall; input and result are registered.
// The state update is one pass of add and compare logic between the input
// register and the result register. Reset sets mode to OAM read, counters
// and line to zero. A stalled result holds; the input side stalls only
// when both registers are full.
module lcd_scanline_mode_timer_top
	import lsmt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [SDataW-1:0] s_axis_tdata,  // ticks, line_compare, irq_enables, pad
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [MDataW-1:0] m_axis_tdata   // mode, line, coincidence, stat_irq,
	                                         // vblank_irq, render_line, pad
);

	flow_t   flow;
	logic    valid_s1;
	item_t   item_s1;
	result_t result;

	lsmt_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.advance  (flow.advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	lsmt_timing u_timing (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (flow.fire),
		.item_s1 (item_s1),
		.result  (result)
	);

	lsmt_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.result    (result),
		.flow      (flow),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

/* rtl/lsmt_in_stage.sv */
// Input register stage of the scanline mode timer.
module lsmt_in_stage
	import lsmt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [SDataW-1:0] in_data,
	input  logic              advance,
	output logic              valid_s1,
	output item_t             item_s1
);

	logic valid_q;

	assign in_ready = !valid_q || advance;
	assign valid_s1 = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_t'(in_data[$bits(item_t)-1:0]);
		end
	end

endmodule

/* rtl/lsmt_timing.sv */
// Frame, line and display mode state with its next-state logic.
module lsmt_timing
	import lsmt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item_s1,
	output result_t result
);

	logic [FrameW-1:0] frame_q;
	logic [PhaseW-1:0] phase_q;
	logic [VblW-1:0]   vbl_q;
	mode_t             mode_q;
	logic [LineW-1:0]  line_q;
	logic              match_q;

	logic [FrameW-1:0] frame_sum, frame_d;
	logic [PhaseW:0]   phase_sum;
	logic [PhaseW-1:0] phase_add, phase_d;
	logic [VblW-1:0]   vbl_sum, vbl_d;
	mode_t             mode_d;
	logic [LineW-1:0]  line_d, line_inc;
	logic              match_d, stat, vbl_irq, render;
	logic              neg, oam;

	assign frame_sum = frame_q + {{(FrameW-TicksW){1'b0}}, item_s1.ticks};
	assign neg       = frame_sum[FrameW-1];
	assign phase_sum = {1'b0, phase_q} + {{(PhaseW+1-TicksW){1'b0}}, item_s1.ticks};
	assign phase_add = (phase_sum >= LINE_CYCLES) ? PhaseW'(phase_sum - LINE_CYCLES)
	                                              : phase_sum[PhaseW-1:0];
	assign phase_d   = frame_q[FrameW-1] ? frame_sum[PhaseW-1:0] : phase_add;
	assign oam       = neg || (phase_d < OAM_END);
	assign line_inc  = line_q + 8'd1;
	assign vbl_sum   = vbl_q + {{(VblW-TicksW){1'b0}}, item_s1.ticks};

	always_comb begin
		frame_d = frame_sum;
		vbl_d   = vbl_q;
		mode_d  = mode_q;
		line_d  = line_q;
		match_d = match_q;
		stat    = 1'b0;
		vbl_irq = 1'b0;
		render  = 1'b0;
		if (neg || frame_sum < VISIBLE_END) begin
			if (oam) begin
				if (mode_q != MODE_OAM) begin
					if (mode_q != MODE_VBLANK) begin
						line_d  = line_inc;
						match_d = (line_inc == item_s1.line_compare);
						stat    = match_d && item_s1.irq_enables[EN_MATCH];
					end
					mode_d = MODE_OAM;
					if (item_s1.irq_enables[EN_OAM]) begin
						stat = 1'b1;
					end
				end
			end else if (phase_d < XFER_END) begin
				mode_d = MODE_XFER;
			end else if (mode_q != MODE_HBLANK) begin
				mode_d = MODE_HBLANK;
				render = 1'b1;
				stat   = item_s1.irq_enables[EN_HBLANK];
			end
		end else if (mode_q != MODE_VBLANK) begin
			mode_d  = MODE_VBLANK;
			vbl_d   = frame_sum[VblW-1:0] - VBL_OFFSET;
			stat    = item_s1.irq_enables[EN_VBLANK];
			vbl_irq = 1'b1;
		end else begin
			vbl_d = vbl_sum;
			if (vbl_sum >= LINE_CYCLES) begin
				vbl_d   = vbl_sum - LINE_CYCLES;
				line_d  = line_inc;
				match_d = (line_inc == item_s1.line_compare);
				stat    = match_d && item_s1.irq_enables[EN_MATCH];
				if (line_inc == LAST_LINE) begin
					frame_d = frame_sum - FRAME_TOTAL;
					line_d  = '0;
					match_d = (item_s1.line_compare == '0);
					if (match_d && item_s1.irq_enables[EN_MATCH]) begin
						stat = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			phase_q <= '0;
			vbl_q   <= '0;
			mode_q  <= MODE_OAM;
			line_q  <= '0;
			match_q <= 1'b0;
		end else if (fire) begin
			frame_q <= frame_d;
			phase_q <= phase_d;
			vbl_q   <= vbl_d;
			mode_q  <= mode_d;
			line_q  <= line_d;
			match_q <= match_d;
		end
	end

	always_comb begin
		result.mode        = mode_d;
		result.line        = line_d;
		result.coincidence = match_d;
		result.stat_irq    = stat;
		result.vblank_irq  = vbl_irq;
		result.render_line = render;
	end

endmodule

/* rtl/lsmt_out_stage.sv */
// Result register stage of the scanline mode timer.
module lsmt_out_stage
	import lsmt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  result_t           result,
	output flow_t             flow,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [MDataW-1:0] out_data
);

	logic    valid_s2;
	result_t result_s2;

	assign flow.advance = !valid_s2 || out_ready;
	assign flow.fire    = valid_s1 && flow.advance;
	assign out_valid    = valid_s2;
	assign out_data     = {{(MDataW-$bits(result_t)){1'b0}}, result_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (flow.advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (flow.fire) begin
			result_s2 <= result;
		end
	end

endmodule

/* rtl/lsmt_checker.sv */
// Port-level checks for the scanline mode timer and their bind.
module lsmt_checker
	import lsmt_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              s_axis_tready,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [MDataW-1:0] m_axis_tdata
);

	result_t res;

	assign res = result_t'(m_axis_tdata[$bits(result_t)-1:0]);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_vbl_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.vblank_irq |-> res.mode == MODE_VBLANK)
		else $error("vblank interrupt outside vblank mode");

	a_render_mode: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.render_line |-> res.mode == MODE_HBLANK && !res.vblank_irq)
		else $error("render pulse outside hblank mode");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

endmodule

bind lcd_scanline_mode_timer_top lsmt_checker u_lsmt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
